// ----- design/ctma_pkg.sv -----
package ctma_pkg;

  localparam int SAMPLE_W  = 12;
  localparam int CAL_W     = 16;
  localparam int TEMP_W    = 16;
  localparam int MAG_W     = TEMP_W + 1;
  localparam int CODE_MAX  = 4095;

  // configuration register map
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_CAL_LOW  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_CAL_HIGH = 1'b1;

  // calibration arithmetic, tenths of a degree
  localparam int CEL_SCALE  = 550;   // 55.0 C span between the two points
  localparam int CEL_OFFSET = 300;   // 30.0 C at the low point
  localparam int FAH_SCALE  = 9;
  localparam int FAH_DEN    = 5;
  localparam int FAH_OFFSET = 1600;  // 32.0 F times 5 times 10

  localparam int CEL_LIMIT   = 20000;
  localparam int FAH_POS_LIM = 32767;
  localparam int FAH_NEG_LIM = 32768;
  localparam logic signed [TEMP_W-1:0] CEL_INVALID = -16'sd9999;
  localparam logic signed [TEMP_W-1:0] FAH_INVALID = -16'sd17678;

  // datapath widths
  localparam int NUM_W   = 24;  // celsius numerator, signed
  localparam int NUM2_W  = 28;  // fahrenheit numerator, signed
  localparam int DIV1_NW = 23;  // 2|num| + d
  localparam int DIV1_DW = 13;  // 2d
  localparam int DIV2_NW = 27;  // 2|num2| + 5d
  localparam int DIV2_DW = 16;  // 10d

  typedef logic [SAMPLE_W-1:0] code_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ----- design/ctma_sample_if.sv -----
interface ctma_sample_if import ctma_pkg::*; ();
  logic  valid;
  logic  ready;
  code_t sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

// ----- design/ctma_result_if.sv -----
interface ctma_result_if import ctma_pkg::*; ();
  logic                     valid;
  logic                     ready;
  code_t                    average_code;
  logic signed [TEMP_W-1:0] celsius_tenths;
  logic signed [TEMP_W-1:0] fahrenheit_tenths;
  logic                     calibration_ok;

  modport source (output valid, output average_code, output celsius_tenths,
                  output fahrenheit_tenths, output calibration_ok, input ready);
  modport sink   (input valid, input average_code, input celsius_tenths,
                  input fahrenheit_tenths, input calibration_ok, output ready);
endinterface

// ----- design/calibrated_temperature_moving_average_core.sv -----
// Boxcar moving average of 12-bit temperature sensor codes, with a
// two-point (30 C / 85 C) calibration to tenths of a degree C and F.
//
// Channels: in_ch takes one sample per transaction (valid/ready); out_ch
// gives one result per sample: average code, Celsius and Fahrenheit tenths
// and the calibration flag. cfg_we/cfg_idx/cfg_wdata write the low and high
// calibration points; write them only while the block is idle.
//
// Sequence: an input transaction reads the window slot (skipped for the
// first sample after reset), updates the running sum, divides it by the
// window length in a bit-serial divider, forms the calibration numerators
// and then runs the bit-serial Celsius and Fahrenheit dividers in parallel;
// an invalid calibration skips those two dividers. One sample is in flight
// at a time; in_ch.ready rises together with out_ch.valid, so a new
// transaction is taken only after the previous result is loaded.
//
// Reset: window empty, calibration points zero (calibration invalid). The
// first sample after reset stands for every window slot.
// A stalled receiver holds the result in the output register; the next
// sample is still taken and its result waits in the done state until the register frees up.
module calibrated_temperature_moving_average_core import ctma_pkg::*; #(
  parameter int WINDOW_LENGTH = 36
) (
  input  logic                 clk,
  input  logic                 rst_n,
  ctma_sample_if.sink          in_ch,
  ctma_result_if.source        out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CAL_W-1:0]     cfg_wdata
);

  localparam int SLOT_W = $clog2(WINDOW_LENGTH);
  localparam int CNT_W  = $clog2(WINDOW_LENGTH + 1);
  localparam int SUM_W  = SAMPLE_W + $clog2(WINDOW_LENGTH);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_READ = 4'd1;
  localparam logic [3:0] S_UPD  = 4'd2;
  localparam logic [3:0] S_AVG  = 4'd3;
  localparam logic [3:0] S_AVGW = 4'd4;
  localparam logic [3:0] S_CAL1 = 4'd5;
  localparam logic [3:0] S_CAL2 = 4'd6;
  localparam logic [3:0] S_CAL3 = 4'd7;
  localparam logic [3:0] S_CAL4 = 4'd8;
  localparam logic [3:0] S_DIV  = 4'd9;
  localparam logic [3:0] S_DIVW = 4'd10;
  localparam logic [3:0] S_DONE = 4'd11;

  // control state
  logic [3:0]       state_r, state_nxt;
  logic             primed_r, primed_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;     // slots written since priming
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [CAL_W-1:0] cal_low_r, cal_high_r;
  logic             out_vld_r, out_vld_nxt;

  // payload
  code_t            samp_r, samp_nxt;
  code_t            first_r, first_nxt;   // stands in for unwritten slots
  code_t            avg_r, avg_nxt;
  logic             ok_r, ok_nxt;
  logic [SAMPLE_W-1:0] d_r, d_nxt;
  logic signed [NUM_W-1:0]  prod_r, prod_nxt;
  logic signed [NUM_W-1:0]  pterm_r, pterm_nxt;
  logic signed [NUM_W-1:0]  num_r, num_nxt;
  logic signed [NUM2_W-1:0] n2_r, n2_nxt;
  logic [DIV1_NW-1:0] a1_r, a1_nxt;
  logic [DIV1_DW-1:0] q1_r, q1_nxt;
  logic [DIV2_NW-1:0] a2_r, a2_nxt;
  logic [DIV2_DW-1:0] q2_r, q2_nxt;
  logic             neg1_r, neg1_nxt;
  logic             neg2_r, neg2_nxt;
  logic signed [TEMP_W-1:0] cel_r, cel_nxt;
  logic signed [TEMP_W-1:0] fah_r, fah_nxt;
  code_t            o_avg_r, o_avg_nxt;
  logic signed [TEMP_W-1:0] o_cel_r, o_cel_nxt;
  logic signed [TEMP_W-1:0] o_fah_r, o_fah_nxt;
  logic             o_ok_r, o_ok_nxt;

  logic             in_acc;
  logic             out_free;
  logic             ram_we;
  code_t            ram_rdata;
  code_t            old_code;
  logic signed [SAMPLE_W:0] diff;
  logic [SAMPLE_W-1:0] dcomb;
  logic             cal_ok;
  logic [NUM_W-1:0]  abs1;
  logic [NUM2_W-1:0] abs2;
  logic [MAG_W-1:0]  mag1, mag2;
  int                fah_lim;

  logic              avg_start, cal_start;
  logic [SUM_W-1:0]  avg_q;
  logic [DIV1_NW-1:0] cel_q;
  logic [DIV2_NW-1:0] fah_q;
  div_stat_t         avg_st, cel_st, fah_st;

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_free = !out_vld_r || out_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);

  assign ram_we    = (state_r == S_UPD);
  assign avg_start = (state_r == S_AVG);
  assign cal_start = (state_r == S_DIV);

  ctma_ram #(.WIDTH(SAMPLE_W), .DEPTH(WINDOW_LENGTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot_r),
    .wdata (samp_r),
    .raddr (slot_r),
    .rdata (ram_rdata)
  );

  ctma_div #(.NW(SUM_W), .DW(CNT_W)) u_div_avg (
    .clk (clk), .rst_n (rst_n), .start (avg_start),
    .num (sum_r), .den (CNT_W'(WINDOW_LENGTH)),
    .quot (avg_q), .stat (avg_st)
  );

  ctma_div #(.NW(DIV1_NW), .DW(DIV1_DW)) u_div_cel (
    .clk (clk), .rst_n (rst_n), .start (cal_start),
    .num (a1_r), .den (q1_r), .quot (cel_q), .stat (cel_st)
  );

  ctma_div #(.NW(DIV2_NW), .DW(DIV2_DW)) u_div_fah (
    .clk (clk), .rst_n (rst_n), .start (cal_start),
    .num (a2_r), .den (q2_r), .quot (fah_q), .stat (fah_st)
  );

  // calibration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_low_r  <= '0;
      cal_high_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_CAL_LOW:  cal_low_r  <= cfg_wdata;
        REG_CAL_HIGH: cal_high_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // slots not yet written since priming still hold the first sample
  assign old_code = (CNT_W'(slot_r) < fill_r) ? ram_rdata : first_r;

  assign cal_ok = (cal_high_r > cal_low_r) && (cal_high_r <= CAL_W'(CODE_MAX));
  assign dcomb  = cal_high_r[SAMPLE_W-1:0] - cal_low_r[SAMPLE_W-1:0];
  assign diff   = $signed({1'b0, avg_r}) - $signed({1'b0, cal_low_r[SAMPLE_W-1:0]});
  assign abs1   = num_r[NUM_W-1] ? NUM_W'(-num_r) : NUM_W'(num_r);
  assign abs2   = n2_r[NUM2_W-1] ? NUM2_W'(-n2_r) : NUM2_W'(n2_r);

  // magnitude clamp, then sign
  assign mag1    = (cel_q > DIV1_NW'(CEL_LIMIT)) ? MAG_W'(CEL_LIMIT) : MAG_W'(cel_q);
  assign fah_lim = neg2_r ? FAH_NEG_LIM : FAH_POS_LIM;
  assign mag2    = (fah_q > DIV2_NW'(fah_lim)) ? MAG_W'(fah_lim) : MAG_W'(fah_q);

  always_comb begin
    state_nxt   = state_r;
    primed_nxt  = primed_r;
    slot_nxt    = slot_r;
    fill_nxt    = fill_r;
    sum_nxt     = sum_r;
    out_vld_nxt = out_vld_r;
    samp_nxt    = samp_r;
    first_nxt   = first_r;
    avg_nxt     = avg_r;
    ok_nxt      = ok_r;
    d_nxt       = d_r;
    prod_nxt    = prod_r;
    pterm_nxt   = pterm_r;
    num_nxt     = num_r;
    n2_nxt      = n2_r;
    a1_nxt      = a1_r;
    q1_nxt      = q1_r;
    a2_nxt      = a2_r;
    q2_nxt      = q2_r;
    neg1_nxt    = neg1_r;
    neg2_nxt    = neg2_r;
    cel_nxt     = cel_r;
    fah_nxt     = fah_r;
    o_avg_nxt   = o_avg_r;
    o_cel_nxt   = o_cel_r;
    o_fah_nxt   = o_fah_r;
    o_ok_nxt    = o_ok_r;

    if (out_vld_r && out_ch.ready) begin
      out_vld_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          samp_nxt = in_ch.sample;
          if (!primed_r) begin
            // first sample fills the whole window
            primed_nxt = 1'b1;
            first_nxt  = in_ch.sample;
            sum_nxt    = SUM_W'(SUM_W'(in_ch.sample) * SUM_W'(WINDOW_LENGTH));
            slot_nxt   = '0;
            fill_nxt   = '0;
            state_nxt  = S_AVG;
          end else begin
            state_nxt = S_READ;
          end
        end
      end
      S_READ: state_nxt = S_UPD;
      S_UPD: begin
        sum_nxt = sum_r - SUM_W'(old_code) + SUM_W'(samp_r);
        if (slot_r == SLOT_W'(WINDOW_LENGTH - 1)) begin
          slot_nxt = '0;
        end else begin
          slot_nxt = slot_r + SLOT_W'(1);
        end
        if (fill_r != CNT_W'(WINDOW_LENGTH)) begin
          fill_nxt = fill_r + CNT_W'(1);
        end
        state_nxt = S_AVG;
      end
      S_AVG: state_nxt = S_AVGW;
      S_AVGW: begin
        if (avg_st.done) begin
          avg_nxt   = avg_q[SAMPLE_W-1:0];
          state_nxt = S_CAL1;
        end
      end
      S_CAL1: begin
        ok_nxt    = cal_ok;
        d_nxt     = dcomb;
        prod_nxt  = NUM_W'(NUM_W'(diff) * CEL_SCALE);
        pterm_nxt = NUM_W'($signed({1'b0, dcomb}) * CEL_OFFSET);
        if (cal_ok) begin
          state_nxt = S_CAL2;
        end else begin
          cel_nxt   = CEL_INVALID;
          fah_nxt   = FAH_INVALID;
          state_nxt = S_DONE;
        end
      end
      S_CAL2: begin
        num_nxt   = prod_r + pterm_r;
        state_nxt = S_CAL3;
      end
      S_CAL3: begin
        n2_nxt = NUM2_W'(num_r) * NUM2_W'(FAH_SCALE)
               + NUM2_W'($signed({1'b0, d_r}) * FAH_OFFSET);
        // round half away from zero: (2|n| + q) / 2q
        a1_nxt    = DIV1_NW'({abs1, 1'b0}) + DIV1_NW'(d_r);
        q1_nxt    = DIV1_DW'({d_r, 1'b0});
        neg1_nxt  = num_r[NUM_W-1];
        state_nxt = S_CAL4;
      end
      S_CAL4: begin
        a2_nxt    = DIV2_NW'({abs2, 1'b0}) + DIV2_NW'(d_r) * DIV2_NW'(FAH_DEN);
        q2_nxt    = DIV2_DW'(d_r) * DIV2_DW'(2 * FAH_DEN);
        neg2_nxt  = n2_r[NUM2_W-1];
        state_nxt = S_DIV;
      end
      S_DIV: state_nxt = S_DIVW;
      S_DIVW: begin
        if (!cel_st.busy && !fah_st.busy) begin
          cel_nxt   = neg1_r ? TEMP_W'(-mag1) : TEMP_W'(mag1);
          fah_nxt   = neg2_r ? TEMP_W'(-mag2) : TEMP_W'(mag2);
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_vld_nxt = 1'b1;
          o_avg_nxt   = avg_r;
          o_cel_nxt   = cel_r;
          o_fah_nxt   = fah_r;
          o_ok_nxt    = ok_r;
          state_nxt   = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      primed_r  <= 1'b0;
      slot_r    <= '0;
      fill_r    <= '0;
      sum_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      primed_r  <= primed_nxt;
      slot_r    <= slot_nxt;
      fill_r    <= fill_nxt;
      sum_r     <= sum_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    samp_r  <= samp_nxt;
    first_r <= first_nxt;
    avg_r   <= avg_nxt;
    ok_r    <= ok_nxt;
    d_r     <= d_nxt;
    prod_r  <= prod_nxt;
    pterm_r <= pterm_nxt;
    num_r   <= num_nxt;
    n2_r    <= n2_nxt;
    a1_r    <= a1_nxt;
    q1_r    <= q1_nxt;
    a2_r    <= a2_nxt;
    q2_r    <= q2_nxt;
    neg1_r  <= neg1_nxt;
    neg2_r  <= neg2_nxt;
    cel_r   <= cel_nxt;
    fah_r   <= fah_nxt;
    o_avg_r <= o_avg_nxt;
    o_cel_r <= o_cel_nxt;
    o_fah_r <= o_fah_nxt;
    o_ok_r  <= o_ok_nxt;
  end

  assign out_ch.valid             = out_vld_r;
  assign out_ch.average_code      = o_avg_r;
  assign out_ch.celsius_tenths    = o_cel_r;
  assign out_ch.fahrenheit_tenths = o_fah_r;
  assign out_ch.calibration_ok    = o_ok_r;

  // window bookkeeping stays in range
  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(WINDOW_LENGTH) && CNT_W'(slot_r) < CNT_W'(WINDOW_LENGTH))
    else $error("window slot or fill count out of range");

  // priming loads the sum with the sample times the window length
  a_prime_sum: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !primed_r |=> primed_r &&
      sum_r == SUM_W'(SUM_W'($past(in_ch.sample)) * SUM_W'(WINDOW_LENGTH)))
    else $error("priming sum mismatch");

  // no divider runs while a new transaction can be taken
  a_idle_div: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !avg_st.busy && !cel_st.busy && !fah_st.busy)
    else $error("divider busy in idle");

  // a result is only loaded when the sequence finishes
  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_vld_r) |-> $past(state_r) == S_DONE)
    else $error("result loaded outside done state");

  // an invalid calibration never reaches the dividers
  a_bad_cal: assert property (@(posedge clk) disable iff (!rst_n)
    cal_start |-> ok_r)
    else $error("calibration divide started with invalid points");

endmodule

// ----- design/ctma_ram.sv -----
module ctma_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 36
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/ctma_div.sv -----
// Restoring divider for NW-bit dividends, one quotient bit per cycle.
module ctma_div import ctma_pkg::*; #(
  parameter int NW = 18,
  parameter int DW = 7
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [NW-1:0] quot,
  output div_stat_t     stat
);

  localparam int CW = $clog2(NW + 1);

  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [NW-1:0] n_r, n_nxt;     // dividend shifts out, quotient shifts in
  logic [DW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] den_r, den_nxt;
  logic [DW:0]   trial;
  logic [DW:0]   diff;

  always_comb begin
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    n_nxt    = n_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    trial    = {rem_r, n_r[NW-1]};
    diff     = trial - {1'b0, den_r};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(NW);
      n_nxt    = num;
      rem_nxt  = '0;
      den_nxt  = den;
    end else if (busy_r) begin
      if (!diff[DW]) begin
        rem_nxt = diff[DW-1:0];
        n_nxt   = {n_r[NW-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DW-1:0];
        n_nxt   = {n_r[NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r   <= n_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign quot      = n_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule
